>>> src/record_match_reconciler_assert.svh
// assertion macros for the record match reconciler
// depends on nothing; included by the top level only
`ifndef RECORD_MATCH_RECONCILER_ASSERT_SVH
`define RECORD_MATCH_RECONCILER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define RMR_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed: label");

// condition holds in the cycle after the trigger
`define RMR_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: label");

`endif

>>> src/rmr_pkg.sv
// types and constants of the record match reconciler
// depends on nothing; used by record_match_reconciler
package rmr_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int MAX_LIVE    = 64;
    localparam int MAX_SCAN    = (MAX_RECORDS > MAX_LIVE) ? MAX_RECORDS : MAX_LIVE;

    localparam int REC_IDX_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int LIVE_IDX_W = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
    localparam int REC_CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int LIVE_CNT_W = $clog2(MAX_LIVE + 1);
    localparam int SCAN_W     = $clog2(MAX_SCAN + 1);

    localparam int UID_W    = 32;
    localparam int HASH_W   = 32;
    localparam int STAMP_W  = 32;
    localparam int S_DATA_W = 104;  // 97 bits of fields, padded to whole bytes
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;   // 35 bits of fields, padded to whole bytes

    typedef enum logic [1:0] {
        KIND_LOAD_RECORD = 2'd0,
        KIND_LOAD_LIVE   = 2'd1,
        KIND_JUDGE       = 2'd2,
        KIND_CLEAR       = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        VERDICT_KEPT_LIVE    = 3'd0,
        VERDICT_KEPT_MATCHED = 3'd1,
        VERDICT_DISMISS      = 3'd2,
        VERDICT_REKEY        = 3'd3,
        VERDICT_KEPT_NO_HASH = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LIVE = 2'd1,
        ST_REC  = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [STAMP_W-1:0] stamp;
        logic [UID_W-1:0]   uid;
    } rec_entry_t;

    typedef struct packed {
        logic [UID_W-1:0]   uid;
        logic [HASH_W-1:0]  hash;
        logic [STAMP_W-1:0] stamp;
        logic               hash_valid;
    } cand_t;

endpackage

>>> src/record_match_reconciler.sv
// record match reconciler top level: record and live uid memories, scan sequencer
// depends on rmr_pkg and record_match_reconciler_assert.svh
//
// usage
// - input channel s_*: one word per handshake; s_tuser carries the kind
//   (load record, load live uid, judge candidate, clear tables), s_tdata the
//   uid, hash, stamp and hash-valid flag
// - loads and clear complete in the cycle they are accepted and give no word
//   on the output; a load into a full table is dropped
// - a judge word gives exactly one output word on m_* (verdict, new uid)
// - a judge word runs a live uid scan and then a record scan; s_tready returns
//   in the cycle that the verdict is loaded into the output register, which
//   raises m_tvalid; each memory is read one entry a cycle through one port with
//   a registered read, live uids first and then records (only if the hash is valid)
// - a live hit ends the scan early, as does the first exact record match
// - one item is in work at a time; s_tready is high while no judge is running
// - the result waits in an output register, so the next item is taken while
//   the receiver stalls; a second result waits until the register is free
// - reset clears both counts and the output valid flag; memory contents are
//   left as they are and only entries below the counts are ever read
module record_match_reconciler
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    // item_uid[31:0], app_hash[63:32], stamp[95:64], hash_valid[96], zero pad
    input  logic [rmr_pkg::S_DATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [rmr_pkg::S_USER_W-1:0] s_tuser,

    output logic                         m_tvalid,
    input  logic                         m_tready,
    // verdict[2:0], new_uid[34:3], zero pad
    output logic [rmr_pkg::M_DATA_W-1:0] m_tdata
);

    `include "record_match_reconciler_assert.svh"

    // memories
    rmr_pkg::rec_entry_t                rec_mem  [rmr_pkg::MAX_RECORDS];
    logic [rmr_pkg::UID_W-1:0]          live_mem [rmr_pkg::MAX_LIVE];
    rmr_pkg::rec_entry_t                rec_rd_reg;
    logic [rmr_pkg::UID_W-1:0]          live_rd_reg;

    // control state
    rmr_pkg::state_t                    state_reg, state_next;
    logic [rmr_pkg::REC_CNT_W-1:0]      record_count_reg, record_count_next;
    logic [rmr_pkg::LIVE_CNT_W-1:0]     live_count_reg, live_count_next;
    logic [rmr_pkg::SCAN_W-1:0]         scan_reg, scan_next;
    logic                               pend_reg, pend_next;
    logic                               undated_reg, undated_next;
    logic                               out_valid_reg, out_valid_next;

    // payload
    rmr_pkg::cand_t                     cand_reg, cand_next;
    rmr_pkg::verdict_t                  res_verdict_reg, res_verdict_next;
    logic [rmr_pkg::UID_W-1:0]          res_uid_reg, res_uid_next;
    rmr_pkg::verdict_t                  out_verdict_reg, out_verdict_next;
    logic [rmr_pkg::UID_W-1:0]          out_uid_reg, out_uid_next;

    // decoded input word
    logic                               s_accept;
    rmr_pkg::kind_t                     in_kind;
    rmr_pkg::cand_t                     in_word;

    // memory port controls
    logic                               rec_we, live_we, rec_re, live_re;
    logic [rmr_pkg::SCAN_W-1:0]         live_cnt_ext, rec_cnt_ext;

    assign s_tready = (state_reg == rmr_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_kind  = rmr_pkg::kind_t'(s_tuser[1:0]);
    assign in_word.uid        = s_tdata[31:0];
    assign in_word.hash       = s_tdata[63:32];
    assign in_word.stamp      = s_tdata[95:64];
    assign in_word.hash_valid = s_tdata[96];

    assign live_cnt_ext = rmr_pkg::SCAN_W'(live_count_reg);
    assign rec_cnt_ext  = rmr_pkg::SCAN_W'(record_count_reg);

    // one read a cycle while the scan index is below the count
    assign live_re = (state_reg == rmr_pkg::ST_LIVE) && (scan_reg < live_cnt_ext);
    assign rec_re  = (state_reg == rmr_pkg::ST_REC) && (scan_reg < rec_cnt_ext);

    assign rec_we  = s_accept && (in_kind == rmr_pkg::KIND_LOAD_RECORD) &&
                     (record_count_reg < rmr_pkg::REC_CNT_W'(rmr_pkg::MAX_RECORDS));
    assign live_we = s_accept && (in_kind == rmr_pkg::KIND_LOAD_LIVE) &&
                     (live_count_reg < rmr_pkg::LIVE_CNT_W'(rmr_pkg::MAX_LIVE));

    // record memory: write at the fill count, registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[record_count_reg[rmr_pkg::REC_IDX_W-1:0]] <=
                '{hash: in_word.hash, stamp: in_word.stamp, uid: in_word.uid};
        end
        if (rec_re)
        begin
            rec_rd_reg <= rec_mem[scan_reg[rmr_pkg::REC_IDX_W-1:0]];
        end
    end

    // live uid memory
    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_count_reg[rmr_pkg::LIVE_IDX_W-1:0]] <= in_word.uid;
        end
        if (live_re)
        begin
            live_rd_reg <= live_mem[scan_reg[rmr_pkg::LIVE_IDX_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rmr_pkg::ST_IDLE;
            record_count_reg <= '0;
            live_count_reg   <= '0;
            scan_reg         <= '0;
            pend_reg         <= 1'b0;
            undated_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            record_count_reg <= record_count_next;
            live_count_reg   <= live_count_next;
            scan_reg         <= scan_next;
            pend_reg         <= pend_next;
            undated_reg      <= undated_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cand_reg        <= cand_next;
        res_verdict_reg <= res_verdict_next;
        res_uid_reg     <= res_uid_next;
        out_verdict_reg <= out_verdict_next;
        out_uid_reg     <= out_uid_next;
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        record_count_next = record_count_reg;
        live_count_next   = live_count_reg;
        scan_next         = scan_reg;
        pend_next         = live_re || rec_re;
        undated_next      = undated_reg;
        out_valid_next    = out_valid_reg;
        cand_next         = cand_reg;
        res_verdict_next  = res_verdict_reg;
        res_uid_next      = res_uid_reg;
        out_verdict_next  = out_verdict_reg;
        out_uid_next      = out_uid_reg;

        // receiver takes the waiting word
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rmr_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_kind)
                        rmr_pkg::KIND_LOAD_RECORD:
                        begin
                            if (rec_we)
                            begin
                                record_count_next =
                                    rmr_pkg::REC_CNT_W'(record_count_reg + 1'b1);
                            end
                        end
                        rmr_pkg::KIND_LOAD_LIVE:
                        begin
                            if (live_we)
                            begin
                                live_count_next =
                                    rmr_pkg::LIVE_CNT_W'(live_count_reg + 1'b1);
                            end
                        end
                        rmr_pkg::KIND_JUDGE:
                        begin
                            cand_next  = in_word;
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = rmr_pkg::ST_LIVE;
                        end
                        rmr_pkg::KIND_CLEAR:
                        begin
                            record_count_next = '0;
                            live_count_next   = '0;
                        end
                        default:
                        begin
                            state_next = rmr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            rmr_pkg::ST_LIVE:
            begin
                if (pend_reg && (live_rd_reg == cand_reg.uid))
                begin
                    res_verdict_next = rmr_pkg::VERDICT_KEPT_LIVE;
                    res_uid_next     = '0;
                    pend_next        = 1'b0;
                    state_next       = rmr_pkg::ST_DONE;
                end
                else if (!pend_reg && (scan_reg >= live_cnt_ext))
                begin
                    scan_next    = '0;
                    pend_next    = 1'b0;
                    undated_next = 1'b0;
                    if (!cand_reg.hash_valid)
                    begin
                        res_verdict_next = rmr_pkg::VERDICT_KEPT_NO_HASH;
                        res_uid_next     = '0;
                        state_next       = rmr_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = rmr_pkg::ST_REC;
                    end
                end
                else if (live_re)
                begin
                    scan_next = rmr_pkg::SCAN_W'(scan_reg + 1'b1);
                end
            end

            rmr_pkg::ST_REC:
            begin
                // entries come back in load order, so the first exact hit wins
                if (pend_reg && (rec_rd_reg.hash == cand_reg.hash) &&
                    (rec_rd_reg.stamp == cand_reg.stamp))
                begin
                    if (rec_rd_reg.uid != cand_reg.uid)
                    begin
                        res_verdict_next = rmr_pkg::VERDICT_REKEY;
                        res_uid_next     = rec_rd_reg.uid;
                    end
                    else
                    begin
                        res_verdict_next = rmr_pkg::VERDICT_KEPT_MATCHED;
                        res_uid_next     = '0;
                    end
                    pend_next  = 1'b0;
                    state_next = rmr_pkg::ST_DONE;
                end
                else if (!pend_reg && (scan_reg >= rec_cnt_ext))
                begin
                    res_verdict_next = undated_reg ? rmr_pkg::VERDICT_KEPT_MATCHED
                                                   : rmr_pkg::VERDICT_DISMISS;
                    res_uid_next     = '0;
                    pend_next        = 1'b0;
                    state_next       = rmr_pkg::ST_DONE;
                end
                else
                begin
                    if (pend_reg && (rec_rd_reg.hash == cand_reg.hash) &&
                        (rec_rd_reg.stamp == '0))
                    begin
                        undated_next = 1'b1;
                    end
                    if (rec_re)
                    begin
                        scan_next = rmr_pkg::SCAN_W'(scan_reg + 1'b1);
                    end
                end
            end

            rmr_pkg::ST_DONE:
            begin
                // hand the verdict over once the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = res_verdict_reg;
                    out_uid_next     = res_uid_reg;
                    state_next       = rmr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rmr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_uid_reg, out_verdict_reg};

    // checks on the sequencer
    `RMR_ASSERT_NEXT(a_judge_starts_scan, clk, rst_n,
        s_accept && (in_kind == rmr_pkg::KIND_JUDGE), state_reg == rmr_pkg::ST_LIVE)
    `RMR_ASSERT_NOW(a_live_scan_bounded, clk, rst_n,
        state_reg == rmr_pkg::ST_LIVE, scan_reg <= live_cnt_ext)
    `RMR_ASSERT_NOW(a_rec_scan_bounded, clk, rst_n,
        state_reg == rmr_pkg::ST_REC, scan_reg <= rec_cnt_ext)
    `RMR_ASSERT_NEXT(a_done_delivers, clk, rst_n,
        (state_reg == rmr_pkg::ST_DONE) && (!out_valid_reg || m_tready),
        out_valid_reg && (state_reg == rmr_pkg::ST_IDLE))
    `RMR_ASSERT_NOW(a_uid_only_on_rekey, clk, rst_n,
        out_valid_reg && (out_verdict_reg != rmr_pkg::VERDICT_REKEY), out_uid_reg == '0)

endmodule
